>>> design/lps_pkg.sv
`default_nettype none

package lps_pkg;

   // field widths of one request beat and one response beat, plus the modulo bit counter
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 16;
   localparam int RND_W    = 31;
   localparam int STATUS_W = 2;
   localparam int RUNS_W   = 32;
   localparam int BITCNT_W = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET_TICKETS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET_RUNNABLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW         = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_TICKETS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_RUNNABLE = 2'd2;

   // write strobes into the slot table
   typedef struct packed {
      logic tick_we;
      logic mark_we;
      logic runs_we;
   } lps_wr_en_type;

endpackage

`default_nettype wire

>>> design/lottery_process_picker_unit.sv
`default_nettype none

// Lottery scheduler. Each of SLOTS slots keeps a ticket count, a runnable
// mark and a 32-bit run counter in on-chip memory. A set-tickets beat stores
// a count (zero is refused with status 1, counts above the TICKET_BITS
// maximum saturate), a set-runnable beat writes the mark, and a draw beat
// picks a runnable slot with probability proportional to its tickets, clears
// its mark, bumps its run counter and returns slot and new count (status 2
// when nothing is runnable). Slots at or above SLOTS ignore set beats; only
// slots 0..63 are addressable and the reported slot is its low six bits.
// After reset the table is initialised by a clearing pass over every slot,
// during which req_ready stays low. One beat is processed at a time and
// req_ready stays low from acceptance until the block is idle again. A set
// beat goes from idle straight to the response state, where its response is
// loaded into the output register. A draw that finds nothing runnable ends
// after one table sweep to total the tickets; otherwise it goes on with a
// bit-serial modulo of the random word, a second sweep up to the winner, a
// run counter update and the hand-over of the response, all on a single
// shared adder/subtractor and the table's single read port. The response
// sits in an output register, so a new beat is taken while the previous
// response still waits for rsp_ready; a finished beat waits for that
// register to free before the block is ready again.
module lottery_process_picker_unit #(
   parameter int SLOTS       = 64,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [lps_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [lps_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [lps_pkg::COUNT_W-1:0]    req_ticket_count,
   input  wire logic                           req_runnable_flag,
   input  wire logic [lps_pkg::RND_W-1:0]      req_random_word,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [lps_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                rsp_winner_valid,
   output logic      [lps_pkg::SLOT_W-1:0]     rsp_winner_slot,
   output logic      [lps_pkg::RUNS_W-1:0]     rsp_winner_runs
);

   import lps_pkg::*;

   localparam int AB = $clog2(SLOTS);
   localparam int CW = AB + 1;
   // total of all tickets plus one bit of headroom for the modulo shift
   localparam int AW = TICKET_BITS + AB + 1;
   localparam int UW = (AW > RUNS_W) ? AW : RUNS_W;
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SUM   = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_WALK  = 3'd4;
   localparam logic [2:0] S_INC   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [AB-1:0]           rd_idx_ff, rd_idx_in;
   logic [UW-1:0]           acc_ff, acc_in;
   logic [AW-1:0]           tot_ff, tot_in;
   logic [RND_W-1:0]        rnd_ff, rnd_in;
   logic [BITCNT_W-1:0]     bit_ff, bit_in;
   logic [AB-1:0]           win_ff, win_in;

   logic [STATUS_W-1:0]     pend_status_ff, pend_status_in;
   logic                    pend_wvalid_ff, pend_wvalid_in;
   logic [SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [RUNS_W-1:0]       pend_runs_ff, pend_runs_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_wvalid_ff, rsp_wvalid_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [RUNS_W-1:0]       rsp_runs_ff, rsp_runs_in;

   lps_wr_en_type           wr_en;
   logic [AB-1:0]           wr_addr;
   logic [TICKET_BITS-1:0]  wr_tick;
   logic                    wr_mark;
   logic [RUNS_W-1:0]       wr_runs;
   logic [TICKET_BITS-1:0]  rd_tick;
   logic                    rd_mark;
   logic [RUNS_W-1:0]       rd_runs;

   logic [UW-1:0]           alu_a, alu_b, alu_res;
   logic                    alu_sub, alu_borrow;

   logic                    req_beat;
   logic                    slot_in_range;
   logic [TICKET_BITS-1:0]  tick_sat;
   logic [AW-1:0]           rem_shift;
   logic                    sweep_done;

   assign req_ready     = (state_ff == S_IDLE);
   assign req_beat      = req_valid & req_ready;
   assign slot_in_range = (32'(req_slot) < 32'(SLOTS));
   assign tick_sat      = (32'(req_ticket_count) > 32'(TICKET_MAX)) ?
                          TICKET_MAX : TICKET_BITS'(req_ticket_count);
   // next partial remainder: shift in the next bit of the random word
   assign rem_shift     = {acc_ff[AW-2:0], rnd_ff[RND_W-1]};
   // all reads issued and the last read data consumed
   assign sweep_done    = (idx_ff == SLOTS_C) & ~rd_vld_ff;

   lps_table #(
      .SLOTS       (SLOTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_tick (wr_tick),
      .wr_mark (wr_mark),
      .wr_runs (wr_runs),
      .rd_addr (idx_ff[AB-1:0]),
      .rd_tick (rd_tick),
      .rd_mark (rd_mark),
      .rd_runs (rd_runs)
   );

   lps_alu #(
      .WIDTH (UW)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   // operand select for the shared adder/subtractor
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = UW'(rd_tick);
      alu_sub = 1'b0;
      case (state_ff)
         S_SUM: begin
            alu_sub = 1'b0;
         end
         S_MOD: begin
            alu_a   = UW'(rem_shift);
            alu_b   = UW'(tot_ff);
            alu_sub = 1'b1;
         end
         S_WALK: begin
            alu_sub = 1'b1;
         end
         S_INC: begin
            alu_b   = UW'(1'b1);
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // table write port: clearing pass, set beats, winner update
   always_comb begin
      wr_en   = '0;
      wr_addr = AB'(req_slot);
      wr_tick = tick_sat;
      wr_mark = req_runnable_flag;
      wr_runs = alu_res[RUNS_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en   = '{tick_we: 1'b1, mark_we: 1'b1, runs_we: 1'b1};
            wr_addr = idx_ff[AB-1:0];
            wr_tick = TICKET_BITS'(1);
            wr_mark = 1'b0;
            wr_runs = '0;
         end
         S_IDLE: begin
            if (req_beat && slot_in_range) begin
               if (req_cmd == CMD_SET_TICKETS && req_ticket_count != '0) begin
                  wr_en.tick_we = 1'b1;
               end
               if (req_cmd == CMD_SET_RUNNABLE) begin
                  wr_en.mark_we = 1'b1;
               end
            end
         end
         S_INC: begin
            wr_en   = '{tick_we: 1'b0, mark_we: 1'b1, runs_we: 1'b1};
            wr_addr = win_ff;
            wr_mark = 1'b0;
         end
         default: begin
            wr_en = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      acc_in         = acc_ff;
      tot_in         = tot_ff;
      rnd_in         = rnd_ff;
      bit_in         = bit_ff;
      win_in         = win_ff;
      pend_status_in = pend_status_ff;
      pend_wvalid_in = pend_wvalid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_runs_in   = pend_runs_ff;

      // advance the read sweep in both table passes
      if ((state_ff == S_SUM || state_ff == S_WALK) && idx_ff != SLOTS_C) begin
         rd_vld_in = 1'b1;
         rd_idx_in = idx_ff[AB-1:0];
         idx_in    = idx_ff + CW'(1);
      end

      case (state_ff)
         S_CLEAR: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == SLOTS_C - CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               pend_status_in = STAT_OK;
               pend_wvalid_in = 1'b0;
               pend_slot_in   = '0;
               pend_runs_in   = '0;
               state_in       = S_RESP;
               if (req_cmd == CMD_SET_TICKETS && req_ticket_count == '0) begin
                  pend_status_in = STAT_BAD_TICKETS;
               end
               if (req_cmd == CMD_DRAW) begin
                  rnd_in   = req_random_word;
                  acc_in   = '0;
                  idx_in   = '0;
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (rd_vld_ff && rd_mark) begin
               acc_in = alu_res;
            end
            if (sweep_done) begin
               tot_in = acc_ff[AW-1:0];
               acc_in = '0;
               bit_in = BITCNT_W'(RND_W - 1);
               if (acc_ff == '0) begin
                  pend_status_in = STAT_NO_RUNNABLE;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // restoring remainder step: keep the difference unless it borrowed
            acc_in = alu_borrow ? UW'(rem_shift) : alu_res;
            rnd_in = {rnd_ff[RND_W-2:0], 1'b0};
            bit_in = bit_ff - BITCNT_W'(1);
            if (bit_ff == '0) begin
               idx_in   = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // acc holds pick minus one; the winner is the first slot with
            // more tickets than what remains
            if (rd_vld_ff && rd_mark) begin
               if (alu_borrow) begin
                  win_in   = rd_idx_ff;
                  acc_in   = UW'(rd_runs);
                  state_in = S_INC;
               end else begin
                  acc_in = alu_res;
               end
            end else if (sweep_done) begin
               pend_status_in = STAT_NO_RUNNABLE;
               state_in       = S_RESP;
            end
         end
         S_INC: begin
            pend_status_in = STAT_OK;
            pend_wvalid_in = 1'b1;
            pend_slot_in   = SLOT_W'(win_ff);
            pend_runs_in   = alu_res[RUNS_W-1:0];
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: load the pending response once the slot is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_runs_in   = rsp_runs_ff;
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_wvalid_in = pend_wvalid_ff;
         rsp_slot_in   = pend_slot_ff;
         rsp_runs_in   = pend_runs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      acc_ff         <= acc_in;
      tot_ff         <= tot_in;
      rnd_ff         <= rnd_in;
      bit_ff         <= bit_in;
      win_ff         <= win_in;
      pend_status_ff <= pend_status_in;
      pend_wvalid_ff <= pend_wvalid_in;
      pend_slot_ff   <= pend_slot_in;
      pend_runs_ff   <= pend_runs_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_wvalid_ff  <= rsp_wvalid_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_runs_ff    <= rsp_runs_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_winner_valid = rsp_wvalid_ff;
   assign rsp_winner_slot  = rsp_slot_ff;
   assign rsp_winner_runs  = rsp_runs_ff;

endmodule

`default_nettype wire

>>> design/lps_alu.sv
`default_nettype none

module lps_alu #(
   parameter int WIDTH = 48
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic             op_sub,
   output logic      [WIDTH-1:0] result,
   output logic                  borrow
);

   logic [WIDTH:0] full_sum;
   logic [WIDTH-1:0] b_eff;

   // subtract as a + ~b + 1; borrow when no carry out
   assign b_eff    = op_sub ? ~op_b : op_b;
   assign full_sum = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, op_sub};
   assign result   = full_sum[WIDTH-1:0];
   assign borrow   = op_sub & ~full_sum[WIDTH];

endmodule

`default_nettype wire

>>> design/lps_table.sv
`default_nettype none

module lps_table #(
   parameter int SLOTS       = 64,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                         clock,
   input  wire lps_pkg::lps_wr_en_type       wr_en,
   input  wire logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  wire logic [TICKET_BITS-1:0]       wr_tick,
   input  wire logic                         wr_mark,
   input  wire logic [lps_pkg::RUNS_W-1:0]   wr_runs,
   input  wire logic [$clog2(SLOTS)-1:0]     rd_addr,
   output logic      [TICKET_BITS-1:0]       rd_tick,
   output logic                              rd_mark,
   output logic      [lps_pkg::RUNS_W-1:0]   rd_runs
);

   import lps_pkg::*;

   logic [TICKET_BITS-1:0] tick_mem [SLOTS];
   logic                   mark_mem [SLOTS];
   logic [RUNS_W-1:0]      runs_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en.tick_we) begin
         tick_mem[wr_addr] <= wr_tick;
      end
      if (wr_en.mark_we) begin
         mark_mem[wr_addr] <= wr_mark;
      end
      if (wr_en.runs_we) begin
         runs_mem[wr_addr] <= wr_runs;
      end
   end

   always_ff @(posedge clock) begin
      rd_tick <= tick_mem[rd_addr];
      rd_mark <= mark_mem[rd_addr];
      rd_runs <= runs_mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> test/lps_checker.sv
module lps_checker #(
   parameter int SLOTS       = 64,
   parameter int TICKET_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [lps_pkg::CMD_W-1:0]    req_cmd,
   input  logic [lps_pkg::SLOT_W-1:0]   req_slot,
   input  logic [lps_pkg::COUNT_W-1:0]  req_ticket_count,
   input  logic                         req_runnable_flag,
   input  logic [lps_pkg::RND_W-1:0]    req_random_word,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [lps_pkg::STATUS_W-1:0] rsp_status,
   input  logic                         rsp_winner_valid,
   input  logic [lps_pkg::SLOT_W-1:0]   rsp_winner_slot,
   input  logic [lps_pkg::RUNS_W-1:0]   rsp_winner_runs,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam logic [31:0] TICKET_MAX = (32'd1 << TICKET_BITS) - 32'd1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                win;
      logic [SLOT_W-1:0]   slot;
      logic [RUNS_W-1:0]   runs;
   } picker_outcome_type;

   logic [31:0]        slot_tickets [SLOTS];
   logic               slot_runnable [SLOTS];
   logic [RUNS_W-1:0]  slot_runs [SLOTS];
   picker_outcome_type awaited_outcomes [$];
   int                 errors = 0;

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      errors++;
   endtask

   // apply one request beat to the local copy of the table and return its response
   function automatic picker_outcome_type predict_outcome(
      input logic [CMD_W-1:0]   cmd,
      input logic [SLOT_W-1:0]  slot,
      input logic [COUNT_W-1:0] count,
      input logic               flag,
      input logic [RND_W-1:0]   rnd
   );
      picker_outcome_type res;
      logic [31:0]        total;
      logic [31:0]        pick;
      bit                 found;
      res   = '0;
      total = '0;
      found = 1'b0;
      case (cmd)
         CMD_SET_TICKETS: begin
            if (count == '0)
               res.status = STAT_BAD_TICKETS;
            else if (int'(slot) < SLOTS)
               slot_tickets[slot] = (32'(count) > TICKET_MAX) ? TICKET_MAX : 32'(count);
         end
         CMD_SET_RUNNABLE: begin
            if (int'(slot) < SLOTS)
               slot_runnable[slot] = flag;
         end
         CMD_DRAW: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_runnable[i])
                  total += slot_tickets[i];
            if (total == '0) begin
               res.status = STAT_NO_RUNNABLE;
            end else begin
               pick = 32'd1 + ({1'b0, rnd} % total);
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && slot_runnable[i]) begin
                     if (pick <= slot_tickets[i]) begin
                        found            = 1'b1;
                        slot_runnable[i] = 1'b0;
                        slot_runs[i]     = slot_runs[i] + 1'b1;
                        res.win          = 1'b1;
                        res.slot         = SLOT_W'(i);
                        res.runs         = slot_runs[i];
                     end else begin
                        pick -= slot_tickets[i];
                     end
                  end
               end
               if (!found)
                  res.status = STAT_NO_RUNNABLE;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      picker_outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_tickets[i]  = 32'd1;
            slot_runnable[i] = 1'b0;
            slot_runs[i]     = '0;
         end
         awaited_outcomes.delete();
      end else begin
         // check the response beat first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("unexpected response status", 0, rsp_status);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_winner_valid !== want.win)
                  report_mismatch("winner_valid", want.win, rsp_winner_valid);
               if (rsp_winner_slot !== want.slot)
                  report_mismatch("winner_slot", want.slot, rsp_winner_slot);
               if (rsp_winner_runs !== want.runs)
                  report_mismatch("winner_runs", want.runs, rsp_winner_runs);
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(predict_outcome(req_cmd, req_slot, req_ticket_count,
                                                       req_runnable_flag, req_random_word));
      end
      fail_count <= errors;
      pending    <= awaited_outcomes.size();
   end

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   // cmd 3 is not decoded by the block; it must come back as a plain OK
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 400;
   localparam int TARGET_BEATS = 950;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [SLOT_W-1:0]   req_slot;
   logic [COUNT_W-1:0]  req_ticket_count;
   logic                req_runnable_flag;
   logic [RND_W-1:0]    req_random_word;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_winner_valid;
   logic [SLOT_W-1:0]   rsp_winner_slot;
   logic [RUNS_W-1:0]   rsp_winner_runs;

   int fail_count;
   int pending;

   // steady: no idling on either side; hold_off: ask the receiver for a long stall
   bit steady   = 1'b0;
   bit hold_off = 1'b0;

   int beats   = 0;
   int draws   = 0;
   int refused = 0;
   int unused  = 0;

   always #5 clock = ~clock;

   lottery_process_picker_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_ticket_count  (req_ticket_count),
      .req_runnable_flag (req_runnable_flag),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_winner_valid  (rsp_winner_valid),
      .rsp_winner_slot   (rsp_winner_slot),
      .rsp_winner_runs   (rsp_winner_runs)
   );

   lps_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_ticket_count  (req_ticket_count),
      .req_runnable_flag (req_runnable_flag),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_winner_valid  (rsp_winner_valid),
      .rsp_winner_slot   (rsp_winner_slot),
      .rsp_winner_runs   (rsp_winner_runs),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // ticket counts: often small so that draws land on many slots, some wide,
   // now and then the top value, and full-width noise that may hit zero
   function automatic logic [COUNT_W-1:0] pick_tickets();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return COUNT_W'($urandom_range(1, 16));
         4, 5, 6:    return COUNT_W'($urandom_range(1, 4095));
         7, 8:       return COUNT_W'($urandom);
         default:    return '1;
      endcase
   endfunction

   function automatic logic [RND_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return RND_W'($urandom);
      endcase
   endfunction

   // Offer one beat and hold it until the block takes it. Valid is left high on
   // return; the next call lowers it only when it actually idles, so valid is
   // never dropped and raised again in the same step.
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [COUNT_W-1:0] count, input logic flag,
                            input logic [RND_W-1:0] rnd);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_slot          <= slot;
      req_ticket_count  <= count;
      req_runnable_flag <= flag;
      req_random_word   <= rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats++;
      if (cmd == CMD_DRAW)
         draws++;
      if (cmd == CMD_SET_TICKETS && count == '0)
         refused++;
      if (cmd == CMD_UNUSED)
         unused++;
   endtask

   // unused fields carry random bits so that every input bit toggles
   task automatic set_tickets(input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count);
      send_beat(CMD_SET_TICKETS, slot, count, 1'($urandom), pick_word());
   endtask

   task automatic set_mark(input logic [SLOT_W-1:0] slot, input logic flag);
      send_beat(CMD_SET_RUNNABLE, slot, COUNT_W'($urandom), flag, pick_word());
   endtask

   task automatic draw_winner(input logic [RND_W-1:0] rnd);
      send_beat(CMD_DRAW, SLOT_W'($urandom), COUNT_W'($urandom), 1'($urandom), rnd);
   endtask

   // drop valid and wait until every response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Receiver: random stall before each beat, or a long hold-off when asked.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Stimulus: directed corner cases, then random episodes.
   initial begin
      bit pressured;
      bit wide_done;
      int k;
      int n;
      logic [SLOT_W-1:0] s;

      pressured = 1'b0;
      wide_done = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cmd           = CMD_SET_TICKETS;
      req_slot          = '0;
      req_ticket_count  = '0;
      req_runnable_flag = 1'b0;
      req_random_word   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nothing runnable straight after reset
      draw_winner('0);
      // zero tickets are refused whatever the slot
      set_tickets(6'd0, '0);
      set_tickets(6'd63, '0);
      set_tickets(6'd63, '1);
      set_tickets(6'd0, 16'd1);
      set_mark(6'd0, 1'b1);
      set_mark(6'd63, 1'b1);
      set_mark(6'd21, 1'b1);
      set_mark(6'd21, 1'b0);
      // lowest word picks the first runnable slot, top word the remaining one
      draw_winner('0);
      draw_winner('1);
      draw_winner(31'h2AAAAAAA);
      set_tickets(6'd42, 16'hAAAA);
      set_tickets(6'd21, 16'h5555);
      set_mark(6'd42, 1'b1);
      set_mark(6'd21, 1'b1);
      set_mark(6'd63, 1'b1);
      draw_winner(31'h2AAAAAAA);
      draw_winner(31'h55555555);
      send_beat(CMD_UNUSED, 6'h2A, 16'h5555, 1'b1, 31'h2AAAAAAA);
      send_beat(CMD_UNUSED, 6'h15, 16'hAAAA, 1'b0, 31'h55555555);
      draw_winner(pick_word());
      draw_winner(pick_word());

      while (beats < TARGET_BEATS) begin
         steady = ($urandom_range(0, 4) == 0);

         if (!pressured && beats >= 400) begin
            // fill the block while responses are held back
            drain();
            hold_off = 1'b1;
            steady   = 1'b1;
            repeat (16) set_mark(SLOT_W'($urandom), 1'($urandom));
            steady    = 1'b0;
            pressured = 1'b1;
         end

         if (!wide_done || $urandom_range(0, 39) == 0) begin
            // whole table runnable: long sweeps and deep walks
            for (int i = 0; i < 64; i++)
               if ($urandom_range(0, 1) == 0)
                  set_tickets(SLOT_W'(i), pick_tickets());
            for (int i = 0; i < 64; i++)
               set_mark(SLOT_W'(i), 1'b1);
            repeat ($urandom_range(8, 20)) draw_winner(pick_word());
            wide_done = 1'b1;
         end else if ($urandom_range(0, 99) < 85) begin
            // well-formed round: load a few slots, mark them, draw them out
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
               s = SLOT_W'($urandom);
               if ($urandom_range(0, 3) != 0)
                  set_tickets(s, pick_tickets());
               set_mark(s, 1'b1);
            end
            if ($urandom_range(0, 4) == 0)
               set_mark(SLOT_W'($urandom), 1'b0);
            repeat ($urandom_range(1, k + 2)) draw_winner(pick_word());
         end else begin
            // noise: any command, any field values
            n = $urandom_range(1, 4);
            repeat (n)
               send_beat(CMD_W'($urandom_range(0, 3)), SLOT_W'($urandom),
                         COUNT_W'($urandom_range(0, 3) == 0 ? 0 : $urandom),
                         1'($urandom), pick_word());
         end

         if ($urandom_range(0, 9) == 0)
            drain();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d request beats: %0d draws, %0d refused ticket counts, %0d unused commands.",
               beats, draws, refused, unused);
      $display("Both channels stalled at random, with one %0d-cycle response hold-off and drained pauses.",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
